### hdl/depth_edge_pixel_remover_core_assert.svh
// Assertion macros used by the job queue of the depth edge pixel remover.
`ifndef DEPTH_EDGE_PIXEL_REMOVER_CORE_ASSERT_SVH
`define DEPTH_EDGE_PIXEL_REMOVER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DEPR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define DEPR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/depr_pkg.sv
// Types and constants shared by the depth edge pixel remover modules.
`default_nettype none

package depr_pkg;

	localparam int DEPTH_W = 16;
	localparam int COUNT_W = 3;
	localparam int WIDTH_W = 11;
	localparam int ROW_W   = 12;
	localparam int MIN_DIM = 3;

	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_DIFF_THR  = 2'd0;
	localparam logic [IDX_W-1:0] REG_COUNT_THR = 2'd1;
	localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd2;
	localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd3;

	localparam logic [DEPTH_W-1:0] DIFF_THR_RST  = 16'd1000;
	localparam logic [COUNT_W-1:0] COUNT_THR_RST = 3'd1;
	localparam logic [WIDTH_W-1:0] WIDTH_RST     = 11'd640;
	localparam logic [ROW_W-1:0]   HEIGHT_RST    = 12'd480;

	// Job queue between the classifier and the result sequencer.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_in;
		logic               frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_out;
		logic               end_of_frame;
		logic               last_in_run;
	} pix_out_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] diff_threshold;
		logic [COUNT_W-1:0] count_threshold;
		logic [WIDTH_W-1:0] image_width;
		logic [ROW_W-1:0]   image_height;
	} cfg_t;

	// One job per pixel that produces output: the filtered pixel of the row
	// above and, on the last row, the pixel itself.
	typedef struct packed {
		logic [DEPTH_W-1:0] res;
		logic [DEPTH_W-1:0] pix;
		logic               two;
		logic               eof;
	} job_t;

	typedef struct packed {
		logic [QCW-1:0] level;
		logic           empty;
	} q_stat_t;

endpackage

`default_nettype wire

### hdl/depth_edge_pixel_remover_core.sv
// Top level of the depth edge pixel remover (four-neighbour flying pixel filter).
//
//  channel  | handshake           | payload                                  | dir
//  ---------+---------------------+------------------------------------------+-----
//  pixel    | push / full         | depth_in, frame_start (pix_in_t)         | in
//  result   | empty / pop         | depth_out, end_of_frame, last_in_run     | out
//  config   | cfg_we              | cfg_idx, cfg_wdata                       | in
//
//  One pixel is taken per cycle while full is low; its job passes the stage 1
//  and stage 2 registers before the queue write. Row 0 gives no beat, rows
//  1 .. h-2 one beat per pixel and the last row two, so on the last row the
//  result side drains at one pixel per two pops; the four-entry job queue sets
//  how long it may stall. Reset clears counters, queue and config to their
//  defaults; the line stores are not cleared and need no clearing pass.
`default_nettype none

module depth_edge_pixel_remover_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [depr_pkg::IDX_W-1:0]     cfg_idx,
	input  wire logic [depr_pkg::DEPTH_W-1:0]   cfg_wdata,
	input  wire logic                           push,
	input  wire depr_pkg::pix_in_t              pixel,
	output logic                                full,
	output logic                                empty,
	input  wire logic                           pop,
	output depr_pkg::pix_out_t                  result
);

	depr_pkg::cfg_t    cfg_q;
	depr_pkg::job_t    job, head;
	depr_pkg::q_stat_t qstat;
	logic              job_we;
	logic              deq;

	// Register file: take a write whenever the enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_threshold  <= depr_pkg::DIFF_THR_RST;
			cfg_q.count_threshold <= depr_pkg::COUNT_THR_RST;
			cfg_q.image_width     <= depr_pkg::WIDTH_RST;
			cfg_q.image_height    <= depr_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				depr_pkg::REG_DIFF_THR: begin
					cfg_q.diff_threshold <= cfg_wdata;
				end
				depr_pkg::REG_COUNT_THR: begin
					cfg_q.count_threshold <= cfg_wdata[depr_pkg::COUNT_W-1:0];
				end
				depr_pkg::REG_WIDTH: begin
					cfg_q.image_width <= cfg_wdata[depr_pkg::WIDTH_W-1:0];
				end
				depr_pkg::REG_HEIGHT: begin
					cfg_q.image_height <= cfg_wdata[depr_pkg::ROW_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Front: track position, update the line stores, classify the pixel
	// of the row above and hand a job to the queue.
	depr_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.pixel  (pixel),
		.qstat  (qstat),
		.full   (full),
		.job_we (job_we),
		.job    (job)
	);

	// Queue: hold jobs so the result side can stall on its own.
	depr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_we),
		.wr_job (job),
		.rd_en  (deq),
		.head   (head),
		.stat   (qstat)
	);

	// Back: present each job as one beat, or two on the last row, and
	// advance the queue after the final beat of a job.
	depr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.empty  (empty),
		.result (result),
		.deq    (deq)
	);

endmodule

`default_nettype wire

### hdl/depr_front.sv
// Front end: frame position, line stores and edge classification.
`default_nettype none

module depr_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire depr_pkg::cfg_t    cfg,
	input  wire logic              push,
	input  wire depr_pkg::pix_in_t pixel,
	input  wire depr_pkg::q_stat_t qstat,
	output logic                   full,
	output logic                   job_we,
	output depr_pkg::job_t         job
);

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WB > depr_pkg::WIDTH_W) ? WB : depr_pkg::WIDTH_W;
	localparam int RB = depr_pkg::ROW_W;
	localparam int DW = depr_pkg::DEPTH_W;

	logic [DW-1:0] newer_mem [MAX_WIDTH];
	logic [DW-1:0] older_mem [MAX_WIDTH];

	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;

	logic          acc;
	logic [EW-1:0] eff_w;
	logic [RB-1:0] eff_h;
	logic [CB-1:0] c0, c;
	logic [RB-1:0] r0, r;
	logic [RB:0]   r_inc, rn_inc;
	logic [EW-1:0] cn;
	logic          last_col, last_row;
	logic [CB-1:0] addr_r;
	logic [CB-1:0] col_d;
	logic [RB-1:0] row_d;

	logic          v_s1, has_s1, int_s1, two_s1, eof_s1, byp_s1;
	logic [CB-1:0] c_s1;
	logic [DW-1:0] pix_s1;
	logic [DW-1:0] centre_rd, right_rd, up_rd;
	logic [DW-1:0] prevc_q;
	logic [DW-1:0] up_v;
	logic [3:0]    far;

	logic          v_s2, has_s2, int_s2, two_s2, eof_s2;
	logic [3:0]    far_s2;
	logic [DW-1:0] centre_s2, pix_s2;
	logic [depr_pkg::COUNT_W-1:0] cnt;

	logic [depr_pkg::QCW+1:0] busy;

	function automatic logic far_apart(input logic [DW-1:0] a, input logic [DW-1:0] b,
			input logic [DW-1:0] thr);
		logic [DW-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d > thr;
	endfunction

	// Reserve a queue slot for every item still in the two stages.
	assign busy = (depr_pkg::QCW + 2)'(qstat.level) + (depr_pkg::QCW + 2)'(v_s1)
		+ (depr_pkg::QCW + 2)'(v_s2);
	assign full = busy >= (depr_pkg::QCW + 2)'(depr_pkg::QDEPTH);
	assign acc  = push && !full;

	always_comb begin
		eff_w = EW'(cfg.image_width);
		if (eff_w < EW'(depr_pkg::MIN_DIM)) begin
			eff_w = EW'(depr_pkg::MIN_DIM);
		end else if (eff_w > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end
		eff_h = (cfg.image_height < RB'(depr_pkg::MIN_DIM)) ? RB'(depr_pkg::MIN_DIM)
			: cfg.image_height;

		c0 = pixel.frame_start ? '0 : col_q;
		r0 = pixel.frame_start ? '0 : row_q;
		// Counters left past the geometry start a new row or frame.
		if (EW'(c0) >= eff_w) begin
			c     = '0;
			r_inc = (RB+1)'(r0) + 1'b1;
		end else begin
			c     = c0;
			r_inc = (RB+1)'(r0);
		end
		r = (r_inc >= (RB+1)'(eff_h)) ? '0 : r_inc[RB-1:0];

		cn       = EW'(c) + 1'b1;
		last_col = cn >= eff_w;
		rn_inc   = (RB+1)'(r) + 1'b1;
		last_row = rn_inc >= (RB+1)'(eff_h);
		addr_r   = (c == CB'(MAX_WIDTH - 1)) ? '0 : CB'(cn);

		if (last_col) begin
			col_d = '0;
			row_d = last_row ? '0 : rn_inc[RB-1:0];
		end else begin
			col_d = CB'(cn);
			row_d = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// Newer row store: write the incoming pixel, read centre and right.
	always_ff @(posedge clk) begin
		if (acc) begin
			newer_mem[c] <= pixel.depth_in;
			centre_rd    <= newer_mem[c];
			right_rd     <= newer_mem[addr_r];
		end
	end

	// Older row store: read up at accept, write the centre in the following cycle.
	always_ff @(posedge clk) begin
		if (acc) begin
			up_rd <= older_mem[c];
		end
		if (v_s1) begin
			older_mem[c_s1] <= centre_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c_s1   <= c;
			pix_s1 <= pixel.depth_in;
			has_s1 <= r != '0;
			int_s1 <= (r >= RB'(2)) && (c != '0) && !last_col;
			two_s1 <= last_row;
			eof_s1 <= last_col;
			// The older store write of the item in stage 1 lands on this edge.
			byp_s1 <= v_s1 && (c_s1 == c);
		end
		if (v_s1) begin
			prevc_q <= centre_rd;
		end
	end

	// prevc_q holds the previous centre: the left neighbour, and the up
	// neighbour when the store write has not landed yet.
	always_comb begin
		up_v   = byp_s1 ? prevc_q : up_rd;
		far[0] = far_apart(centre_rd, prevc_q, cfg.diff_threshold);
		far[1] = far_apart(centre_rd, up_v, cfg.diff_threshold);
		far[2] = far_apart(centre_rd, pix_s1, cfg.diff_threshold);
		far[3] = far_apart(centre_rd, right_rd, cfg.diff_threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			far_s2    <= far;
			centre_s2 <= centre_rd;
			pix_s2    <= pix_s1;
			has_s2    <= has_s1;
			int_s2    <= int_s1;
			two_s2    <= two_s1;
			eof_s2    <= eof_s1;
		end
	end

	assign cnt = depr_pkg::COUNT_W'(far_s2[0]) + depr_pkg::COUNT_W'(far_s2[1])
		+ depr_pkg::COUNT_W'(far_s2[2]) + depr_pkg::COUNT_W'(far_s2[3]);

	// Drop row-0 items here: they produce no beat.
	assign job_we   = v_s2 && has_s2;
	assign job.res  = (int_s2 && (cnt >= cfg.count_threshold)) ? '0 : centre_s2;
	assign job.pix  = pix_s2;
	assign job.two  = two_s2;
	assign job.eof  = eof_s2;

endmodule

`default_nettype wire

### hdl/depr_queue.sv
// Short job queue between the classifier and the result sequencer.
`default_nettype none

module depr_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire depr_pkg::job_t   wr_job,
	input  wire logic             rd_en,
	output depr_pkg::job_t        head,
	output depr_pkg::q_stat_t     stat
);

	`include "depth_edge_pixel_remover_core_assert.svh"

	depr_pkg::job_t slot_q [depr_pkg::QDEPTH];

	logic [depr_pkg::QAW-1:0] wp_q, rp_q;
	logic [depr_pkg::QCW-1:0] level_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == depr_pkg::QAW'(depr_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= (rp_q == depr_pkg::QAW'(depr_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				level_q <= level_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign head       = slot_q[rp_q];
	assign stat.level = level_q;
	assign stat.empty = level_q == '0;

	`DEPR_ASSERT_NOW(a_no_overflow, wr_en, level_q != depr_pkg::QCW'(depr_pkg::QDEPTH), "job queue overflow")
	`DEPR_ASSERT_NOW(a_no_underflow, rd_en, level_q != '0, "job queue read while empty")
	`DEPR_ASSERT_NEXT(a_level_up, wr_en && !rd_en, level_q == $past(level_q) + 1'b1, "level not advanced on write")
	`DEPR_ASSERT_NEXT(a_level_down, rd_en && !wr_en, level_q == $past(level_q) - 1'b1, "level not dropped on read")

endmodule

`default_nettype wire

### hdl/depr_back.sv
// Back end: turns each queued job into one or two result beats.
`default_nettype none

module depr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire depr_pkg::job_t    head,
	input  wire depr_pkg::q_stat_t qstat,
	input  wire logic              pop,
	output logic                   empty,
	output depr_pkg::pix_out_t     result,
	output logic                   deq
);

	logic phase_q;
	logic take;

	assign empty = qstat.empty;
	assign take  = pop && !qstat.empty;
	assign deq   = take && (!head.two || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= head.two && !phase_q;
		end
	end

	assign result.depth_out    = phase_q ? head.pix : head.res;
	assign result.end_of_frame = phase_q && head.eof;
	assign result.last_in_run  = phase_q || !head.two;

endmodule

`default_nettype wire

### verif/depth_edge_pixel_remover_core_checker.sv
// Result predictor and scoreboard for the depth edge pixel remover core.
module depth_edge_pixel_remover_core_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [depr_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [depr_pkg::DEPTH_W-1:0] cfg_wdata,
	input  logic                         push,
	input  logic                         full,
	input  depr_pkg::pix_in_t            pixel,
	input  logic                         empty,
	input  logic                         pop,
	input  depr_pkg::pix_out_t           result,
	output int                           errors,
	output int                           pending,
	output int                           beats
);

	logic [depr_pkg::DEPTH_W-1:0] line_newer [MAX_WIDTH];
	logic [depr_pkg::DEPTH_W-1:0] line_older [MAX_WIDTH];
	int unsigned                  col_pos;
	int unsigned                  row_pos;

	logic [depr_pkg::DEPTH_W-1:0] thr_diff;
	logic [depr_pkg::COUNT_W-1:0] thr_count;
	logic [depr_pkg::WIDTH_W-1:0] width_reg;
	logic [depr_pkg::ROW_W-1:0]   height_reg;

	depr_pkg::pix_out_t filtered_q [$];
	int                 err_cnt  = 0;
	int                 beat_cnt = 0;

	function automatic int unsigned is_far(input logic [depr_pkg::DEPTH_W-1:0] a,
			input logic [depr_pkg::DEPTH_W-1:0] b);
		int gap;
		gap = int'(a) - int'(b);
		if (gap < 0) gap = -gap;
		return (gap > int'(thr_diff)) ? 1 : 0;
	endfunction

	// Advance the raster position by one pixel and queue the beats it releases.
	task automatic filter_pixel(input depr_pkg::pix_in_t p);
		int unsigned                  w;
		int unsigned                  h;
		int unsigned                  c;
		int unsigned                  r;
		int unsigned                  cnt;
		logic [depr_pkg::DEPTH_W-1:0] centre;
		logic [depr_pkg::DEPTH_W-1:0] res;
		depr_pkg::pix_out_t           beat;
		w = (width_reg < depr_pkg::MIN_DIM) ? depr_pkg::MIN_DIM :
			(width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg < depr_pkg::MIN_DIM) ? depr_pkg::MIN_DIM : height_reg;
		if (p.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		c = col_pos;
		r = row_pos;
		centre = line_newer[c];
		if (r >= 1) begin
			// pixel (r-1, c) of the row above
			res = centre;
			if (r >= 2 && c >= 1 && c + 1 < w) begin
				cnt = 0;
				cnt += is_far(centre, line_older[c - 1]);
				cnt += is_far(centre, line_older[c]);
				cnt += is_far(centre, p.depth_in);
				cnt += is_far(centre, line_newer[c + 1]);
				if (cnt >= thr_count) res = '0;
			end
			beat.depth_out    = res;
			beat.end_of_frame = 1'b0;
			beat.last_in_run  = (r + 1 < h);
			filtered_q.push_back(beat);
			if (r + 1 >= h) begin
				// last row is border: pass it straight through
				beat.depth_out    = p.depth_in;
				beat.end_of_frame = (c + 1 >= w);
				beat.last_in_run  = 1'b1;
				filtered_q.push_back(beat);
			end
		end
		line_older[c] = centre;
		line_newer[c] = p.depth_in;
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	task automatic check_beat(input depr_pkg::pix_out_t got);
		depr_pkg::pix_out_t want;
		if (filtered_q.size() == 0) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("unexpected beat: depth %0d eof %0b last %0b",
					got.depth_out, got.end_of_frame, got.last_in_run);
		end else begin
			want = filtered_q.pop_front();
			if (got.depth_out !== want.depth_out ||
					got.end_of_frame !== want.end_of_frame ||
					got.last_in_run !== want.last_in_run) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display({"mismatch: expected depth %0d eof %0b last %0b, ",
						"got depth %0d eof %0b last %0b"},
						want.depth_out, want.end_of_frame, want.last_in_run,
						got.depth_out, got.end_of_frame, got.last_in_run);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_diff   = depr_pkg::DIFF_THR_RST;
			thr_count  = depr_pkg::COUNT_THR_RST;
			width_reg  = depr_pkg::WIDTH_RST;
			height_reg = depr_pkg::HEIGHT_RST;
			col_pos    = 0;
			row_pos    = 0;
			filtered_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					depr_pkg::REG_DIFF_THR:  thr_diff   = cfg_wdata;
					depr_pkg::REG_COUNT_THR: thr_count  = cfg_wdata[depr_pkg::COUNT_W-1:0];
					depr_pkg::REG_WIDTH:     width_reg  = cfg_wdata[depr_pkg::WIDTH_W-1:0];
					depr_pkg::REG_HEIGHT:    height_reg = cfg_wdata[depr_pkg::ROW_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				beat_cnt++;
				check_beat(result);
			end
			if (push && !full) filter_pixel(pixel);
			pending <= filtered_q.size();
			errors  <= err_cnt;
			beats   <= beat_cnt;
		end
	end

endmodule

### verif/depth_edge_pixel_remover_core_tb.sv
// Stimulus and verdict for the depth edge pixel remover core, checked beat by beat.
module depth_edge_pixel_remover_core_tb;

	localparam int     MAX_WIDTH     = 1024;
	localparam int     RANDOM_ITEMS  = 400;   // random pixels before stimulus stops
	localparam int     CALM_ITEMS    = 320;   // past this, both sides run without idling
	localparam int     HOLD_CYCLES   = 200;   // long output hold-off to back up the block
	localparam int     SETTLE_CYCLES = 8;     // pixel-to-queue latency plus margin
	localparam int     DRAIN_LIMIT   = 20000;
	// Watchdog limit for the whole run, with a wide margin over the slowest legal run.
	localparam longint LIMIT_TIME    = 64'd20_000_000;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [depr_pkg::IDX_W-1:0]   cfg_idx   = depr_pkg::REG_DIFF_THR;
	logic [depr_pkg::DEPTH_W-1:0] cfg_wdata = '0;
	logic                         push      = 1'b0;
	depr_pkg::pix_in_t            pixel     = '0;
	logic                         pop       = 1'b0;
	logic                         full;
	logic                         empty;
	depr_pkg::pix_out_t           result;

	int errors;
	int pending;
	int beats;

	// Stimulus-side copy of the geometry, used only to size frames and values.
	int unsigned cur_diff = 1000;
	int unsigned cur_w    = 3;
	int unsigned cur_h    = 3;

	int items_sent  = 0;
	int frames_sent = 0;
	int phases_run  = 0;
	bit calm         = 1'b0;
	bit hold_request = 1'b0;

	// Directed pixels: a frame whose centre is zeroed by its upper neighbour,
	// a frame cut short after four pixels, and a frame whose centre sits
	// exactly on the difference threshold against every neighbour.
	logic [depr_pkg::DEPTH_W-1:0] dir_depth [22] = '{
		16'd0,    16'd65535, 16'd1000,
		16'd2000, 16'd1000,  16'd2000,
		16'd0,    16'd1999,  16'd65535,
		16'd65535, 16'd0, 16'd12345, 16'd54321,
		16'd4000, 16'd3000,  16'd2000,
		16'd3000, 16'd2000,  16'd1000,
		16'd65535, 16'd3000, 16'd0
	};

	always #10 clk = ~clk;

	depth_edge_pixel_remover_core #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.pixel    (pixel),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	depth_edge_pixel_remover_core_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.full     (full),
		.pixel    (pixel),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.errors   (errors),
		.pending  (pending),
		.beats    (beats)
	);

	// Offer one pixel beat; hold it until the block takes it. Push stays high
	// on return so back-to-back beats follow without a break.
	task automatic put_pixel(input logic [depr_pkg::DEPTH_W-1:0] d, input logic fs);
		if (!calm && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		push  <= 1'b1;
		pixel <= '{depth_in: d, frame_start: fs};
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// Mostly values near a per-frame base, spread around the difference
	// threshold, with rail values and fully random samples mixed in.
	function automatic logic [depr_pkg::DEPTH_W-1:0] pick_depth(input int unsigned base);
		int          v;
		int unsigned spread;
		spread = (cur_diff > 30000) ? 30000 : cur_diff + 2;
		case ($urandom_range(0, 11))
			0:       v = 0;
			1:       v = 65535;
			2, 3:    v = $urandom_range(0, 65535);
			default: v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
		endcase
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return depr_pkg::DEPTH_W'(v);
	endfunction

	function automatic int unsigned pick_threshold();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 65535;
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(0, 3000);
		endcase
	endfunction

	// Send count pixels; fresh marks the first one as a frame start.
	task automatic send_frame(input int count, input bit fresh);
		int unsigned base;
		base = $urandom_range(0, 65535);
		for (int i = 0; i < count; i++) put_pixel(pick_depth(base), fresh && i == 0);
		frames_sent++;
	endtask

	// Raw noise: any value, and a frame start now and then.
	task automatic send_noise(input int count);
		for (int i = 0; i < count; i++)
			put_pixel(depr_pkg::DEPTH_W'($urandom_range(0, 65535)),
				$urandom_range(0, 7) == 0);
	endtask

	// Drop push, then wait until every expected beat has been popped and the
	// pipeline has had time to retire pixels that release no beat.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [depr_pkg::IDX_W-1:0] idx, input int unsigned v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= depr_pkg::DEPTH_W'(v);
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned d, input int unsigned c,
			input int unsigned w, input int unsigned h);
		wait_idle();
		write_reg(depr_pkg::REG_DIFF_THR, d);
		write_reg(depr_pkg::REG_COUNT_THR, c);
		write_reg(depr_pkg::REG_WIDTH, w);
		write_reg(depr_pkg::REG_HEIGHT, h);
		cfg_we   <= 1'b0;
		cur_diff = d;
		cur_w    = (w < depr_pkg::MIN_DIM) ? depr_pkg::MIN_DIM :
			(w > MAX_WIDTH) ? MAX_WIDTH : w;
		cur_h    = (h < depr_pkg::MIN_DIM) ? depr_pkg::MIN_DIM : h;
		phases_run++;
	endtask

	// One or two frames per phase, some cut short, some followed by noise.
	task automatic run_mix();
		int n;
		n = $urandom_range(1, 2);
		for (int f = 0; f < n; f++) begin
			if ($urandom_range(0, 9) < 2)
				send_frame($urandom_range(1, cur_w * cur_h - 1), 1'b1);
			else
				send_frame(cur_w * cur_h, 1'b1);
			if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 8));
		end
	endtask

	// Result side: pop in random runs with random hold-off bursts; on request
	// hold off for a long stretch so the block fills and stalls its input.
	initial begin : result_sink
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request <= 1'b0;
				pop          <= 1'b0;
				n = HOLD_CYCLES;
				while (n > 0) begin
					@(posedge clk);
					n--;
				end
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned d;
		int unsigned c;
		int unsigned w;
		int unsigned h;
		int          p;
		int          random_base;
		int          bulk;
		int          drain;
		p    = 0;
		bulk = 0;
		drain = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: keep the reset thresholds, shrink the geometry to 3x3.
		write_reg(depr_pkg::REG_WIDTH, depr_pkg::MIN_DIM);
		write_reg(depr_pkg::REG_HEIGHT, depr_pkg::MIN_DIM);
		cfg_we <= 1'b0;
		for (int i = 0; i < 22; i++)
			put_pixel(dir_depth[i], i == 0 || i == 9 || i == 13);

		// Random part: structured phases first, then random settings.
		random_base = items_sent;
		while (p < 8 || items_sent - random_base - bulk < RANDOM_ITEMS) begin
			if (items_sent - random_base - bulk >= CALM_ITEMS) calm <= 1'b1;
			d = pick_threshold();
			c = $urandom_range(0, 7);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			if (p == 0) begin
				// Shrink the geometry mid-frame: a column past the new width
				// starts a new row, a row past the new height wraps the frame.
				configure(d, 2, 9, 8);
				send_frame(9 * 3 + 5, 1'b1);
				configure(d, 2, 4, 8);
				send_frame(12, 1'b0);
				configure(d, 2, 4, 5);
				send_frame(20, 1'b0);
			end else if (p == 1) begin
				// Tallest frame: never reach the last row, restart instead.
				configure(d, c, $urandom_range(3, 5), 4095);
				send_frame(cur_w * 7, 1'b1);
				send_frame(cur_w * 4, 1'b1);
			end else if (p == 2) begin
				// Oversized width clamps to the full line store: one full row
				// plus the head of the next shows where the row wraps.
				configure(d, $urandom_range(1, 3), 2047, depr_pkg::MIN_DIM);
				send_frame(MAX_WIDTH + 3, 1'b1);
				bulk += MAX_WIDTH + 3;
			end else if (p == 3) begin
				configure(d, c, 8, 6);
				hold_request <= 1'b1;
				send_frame(cur_w * cur_h, 1'b1);
			end else begin
				case (p)
					4: begin
						// zero count threshold: every interior pixel goes to 0
						d = 0;
						c = 0;
					end
					5: begin
						// widest threshold, count beyond four, dims below minimum
						d = 65535;
						c = 7;
						w = 0;
						h = 0;
					end
					6: begin
						c = 5;
						w = 1;
						h = 1;
					end
					7: begin
						d = 0;
						c = 4;
						w = 2;
						h = 2;
					end
					default: ;
				endcase
				configure(d, c, w, h);
				run_mix();
			end
			p++;
		end

		// Drain: wait for every expected beat, bounded, then settle.
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d pixels in %0d frames over %0d settings, %0d result beats checked",
			items_sent, frames_sent, phases_run, beats);
		$display({"run: thresholds at both rails, clamped and full-width geometry, ",
			"mid-frame resize, output held off"});
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("failures: %0d mismatched or unexpected beats, %0d beats missing",
				errors, pending);
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_TIME);
		$display("TB_ERROR");
		$finish;
	end

endmodule
